FILE: hdl/artvs_pkg.sv
// ----------------------------------------------------------------------------
// artvs_pkg
// Shared types and constants of the autoregressive texture vibration synth.
// ----------------------------------------------------------------------------
package artvs_pkg;

  // item modes
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_COEF   = 2'd1;
  localparam logic [1:0] MODE_SCALE  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN = 1'd1;

  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [23:0] GAIN_RESET = 24'd104858;

  // plus or minus 10 in Q4.20
  localparam int DRIVE_LIMIT = 10485760;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXC   = 6'b000010,
    ST_TAP   = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_GAIN  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

endpackage

FILE: hdl/artvs_ram.sv
// ----------------------------------------------------------------------------
// artvs_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module artvs_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // a read of the address being written returns the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/ar_texture_vibration_synth.sv
// ----------------------------------------------------------------------------
// ar_texture_vibration_synth
// All-pole autoregressive vibration synthesizer for haptic texture rendering.
// ----------------------------------------------------------------------------
// A sample transaction holds the input side from acceptance until its result is
// loaded, waiting while a stalled result holds the output register. The tap loop
// covers min(tap_count, MAX_TAPS) taps and reads one history and one coefficient
// word a cycle from the RAMs. Coefficient and noise scale writes do not hold the
// input side. Reset clears all control state, the history fill count and the
// coefficient valid bits at once.
module ar_texture_vibration_synth #(
  parameter int MAX_TAPS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [artvs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [artvs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            mode_i,
  input  logic                                  bank_i,
  input  logic signed [15:0]                    noise_sample_i,
  input  logic [4:0]                            tap_index_i,
  input  logic signed [31:0]                    coefficient_i,
  input  logic [23:0]                           noise_scale_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [24:0]                    drive_value_o,
  output logic signed [31:0]                    raw_sample_o,
  output logic                                  clamped_o
);

  localparam int TAW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW     = $clog2(MAX_TAPS + 1);
  localparam int CDEPTH = 2 * (1 << TAW);
  localparam logic signed [47:0] GainHi = 48'(artvs_pkg::DRIVE_LIMIT);
  localparam logic signed [47:0] GainLo = -GainHi;
  localparam logic signed [47:0] RawHi  = 48'sd2147483647;
  localparam logic signed [47:0] RawLo  = -48'sd2147483648;

  artvs_pkg::state_e state_q, state_d;

  logic [5:0]            tap_count_q;
  logic [23:0]           output_gain_q;
  logic [1:0][23:0]      scale_q;
  logic [CDEPTH-1:0]     coef_vld_q;

  logic                  bank_q;
  logic signed [15:0]    noise_q;
  logic [CW-1:0]         taps_q;
  logic [CW-1:0]         iss_q, iss_d;
  logic [CW-1:0]         fill_q, fill_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [TAW-1:0]        rd_idx_q;
  logic                  cv_q;
  logic                  prod_vld_q, prod_vld_d;
  logic signed [63:0]    prod_q, prod_d;
  logic signed [55:0]    acc_q, acc_d;
  logic signed [31:0]    raw_q, raw_d;

  logic                  out_valid_q, out_valid_d;
  logic signed [24:0]    drive_q;
  logic signed [31:0]    raw_out_q;
  logic                  clamped_q;

  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic                  coef_we;
  logic [TAW:0]          coef_waddr;
  logic [TAW:0]          coef_raddr;
  logic [31:0]           coef_rdata;
  logic                  hist_we;
  logic [TAW-1:0]        hist_waddr;
  logic [31:0]           hist_wdata;
  logic [TAW-1:0]        hist_raddr;
  logic [31:0]           hist_rdata;
  logic signed [31:0]    hist_val;
  logic signed [31:0]    coef_val;
  logic [CW-1:0]         nxt_idx;

  logic signed [31:0]    mul_a;
  logic signed [32:0]    mul_b;
  logic signed [64:0]    mul_p;

  logic signed [55:0]    rsum;
  logic signed [47:0]    r48;
  logic signed [31:0]    raw_sat;
  logic signed [63:0]    gsum;
  logic signed [47:0]    g48;
  logic signed [24:0]    drive_d;
  logic                  hit_d;

  assign accept     = in_valid_i && (state_q == artvs_pkg::ST_IDLE);
  assign in_stall_o = (state_q != artvs_pkg::ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign coef_we    = accept && (mode_i == artvs_pkg::MODE_COEF) && (tap_index_i < MAX_TAPS);
  assign coef_waddr = {bank_i, TAW'(tap_index_i)};

  // entries at or past the fill count hold zero
  assign hist_val = (CW'(rd_idx_q) < fill_q) ? $signed(hist_rdata) : 32'sd0;
  assign coef_val = cv_q ? $signed(coef_rdata) : 32'sd0;
  assign nxt_idx  = CW'(rd_idx_q) + CW'(1);

  assign mul_p = mul_a * mul_b;

  // round to Q11.20 and saturate
  assign rsum = acc_q + 56'sd128;
  assign r48  = rsum[55:8];
  always_comb begin
    if (r48 > RawHi) begin
      raw_sat = 32'sh7FFFFFFF;
    end else if (r48 < RawLo) begin
      raw_sat = -32'sh80000000;
    end else begin
      raw_sat = r48[31:0];
    end
  end

  // round the gained value and clamp to plus or minus 10
  assign gsum = prod_q + 64'sd32768;
  assign g48  = gsum[63:16];
  always_comb begin
    if (g48 > GainHi) begin
      drive_d = GainHi[24:0];
      hit_d   = 1'b1;
    end else if (g48 < GainLo) begin
      drive_d = GainLo[24:0];
      hit_d   = 1'b1;
    end else begin
      drive_d = g48[24:0];
      hit_d   = 1'b0;
    end
  end

  always_comb begin
    state_d    = state_q;
    iss_d      = iss_q;
    fill_d     = fill_q;
    rd_vld_d   = 1'b0;
    prod_vld_d = 1'b0;
    prod_d     = prod_q;
    acc_d      = acc_q;
    raw_d      = raw_q;
    mul_a      = raw_q;
    mul_b      = $signed({9'd0, output_gain_q});
    hist_we    = 1'b0;
    hist_waddr = '0;
    hist_wdata = hist_val;
    hist_raddr = iss_q[TAW-1:0];
    coef_raddr = {bank_q, iss_q[TAW-1:0]};
    out_load   = 1'b0;

    unique case (state_q)
      artvs_pkg::ST_IDLE: begin
        iss_d = '0;
        if (accept && (mode_i == artvs_pkg::MODE_SAMPLE)) begin
          state_d = artvs_pkg::ST_EXC;
        end
      end
      artvs_pkg::ST_EXC: begin
        mul_a   = 32'(noise_q);
        mul_b   = $signed({9'd0, scale_q[bank_q]});
        acc_d   = mul_p[55:0];
        state_d = artvs_pkg::ST_TAP;
      end
      artvs_pkg::ST_TAP: begin
        // issue stage
        if (iss_q < taps_q) begin
          rd_vld_d = 1'b1;
          iss_d    = iss_q + CW'(1);
        end
        // multiply stage, also shifts the history entry one place up
        if (rd_vld_q) begin
          mul_a      = hist_val;
          mul_b      = 33'(coef_val);
          prod_d     = mul_p[63:0];
          prod_vld_d = 1'b1;
          hist_we    = (nxt_idx < MAX_TAPS);
          hist_waddr = nxt_idx[TAW-1:0];
        end
        // accumulate stage, product floored to Q.28
        if (prod_vld_q) begin
          acc_d = acc_q - 56'($signed(prod_q[63:16]));
        end
        if ((iss_q == taps_q) && !rd_vld_q && !prod_vld_q) begin
          state_d = artvs_pkg::ST_ROUND;
        end
      end
      artvs_pkg::ST_ROUND: begin
        raw_d      = raw_sat;
        hist_we    = 1'b1;
        hist_waddr = '0;
        hist_wdata = raw_sat;
        fill_d     = (taps_q == CW'(MAX_TAPS)) ? CW'(MAX_TAPS) : taps_q + CW'(1);
        state_d    = artvs_pkg::ST_GAIN;
      end
      artvs_pkg::ST_GAIN: begin
        prod_d  = mul_p[63:0];
        state_d = artvs_pkg::ST_OUT;
      end
      artvs_pkg::ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = artvs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = artvs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= artvs_pkg::ST_IDLE;
      tap_count_q   <= '0;
      output_gain_q <= artvs_pkg::GAIN_RESET;
      scale_q       <= '0;
      coef_vld_q    <= '0;
      iss_q         <= '0;
      fill_q        <= '0;
      rd_vld_q      <= 1'b0;
      prod_vld_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      iss_q       <= iss_d;
      fill_q      <= fill_d;
      rd_vld_q    <= rd_vld_d;
      prod_vld_q  <= prod_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          artvs_pkg::CFG_TAP_COUNT:   tap_count_q   <= cfg_data_i[5:0];
          artvs_pkg::CFG_OUTPUT_GAIN: output_gain_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && (mode_i == artvs_pkg::MODE_SCALE)) begin
        scale_q[bank_i] <= noise_scale_i;
      end
      if (coef_we) begin
        coef_vld_q[coef_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (mode_i == artvs_pkg::MODE_SAMPLE)) begin
      bank_q  <= bank_i;
      noise_q <= noise_sample_i;
      taps_q  <= (tap_count_q > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(tap_count_q);
    end
    rd_idx_q <= iss_q[TAW-1:0];
    cv_q     <= coef_vld_q[coef_raddr];
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    raw_q    <= raw_d;
    if (out_load) begin
      drive_q   <= drive_d;
      raw_out_q <= raw_q;
      clamped_q <= hit_d;
    end
  end

  artvs_ram #(
    .Width (32),
    .Depth (MAX_TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  artvs_ram #(
    .Width (32),
    .Depth (CDEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coefficient_i),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign drive_value_o = drive_q;
  assign raw_sample_o  = raw_out_q;
  assign clamped_o     = clamped_q;

endmodule

FILE: hdl/artvs_checker.sv
// ----------------------------------------------------------------------------
// artvs_checker
// Port-level checks of the texture vibration synth, bound to the top level.
// ----------------------------------------------------------------------------
module artvs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         mode_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [24:0] drive_value_o,
  input logic signed [31:0] raw_sample_o,
  input logic               clamped_o
);

  localparam logic signed [24:0] Lim = 25'(artvs_pkg::DRIVE_LIMIT);

  // write transactions do not hold the input side
  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i != artvs_pkg::MODE_SAMPLE) |=> !in_stall_o)
    else $error("write transaction held the input side");

  // a sample keeps the block busy
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == artvs_pkg::MODE_SAMPLE) |=> in_stall_o)
    else $error("sample transaction did not start");

  // drive stays within the limit and sits on it when clamped
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_value_o <= Lim) && (drive_value_o >= -Lim) &&
                    (!clamped_o || drive_value_o == Lim || drive_value_o == -Lim))
    else $error("drive value out of range");

  // a new result only follows a busy period
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a sample in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_value_o) &&
                                   $stable(raw_sample_o) && $stable(clamped_o))
    else $error("stalled result changed");

endmodule

bind ar_texture_vibration_synth artvs_checker u_artvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .mode_i        (mode_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .drive_value_o (drive_value_o),
  .raw_sample_o  (raw_sample_o),
  .clamped_o     (clamped_o)
);

FILE: dv/ar_texture_vibration_synth_tb.sv
// ----------------------------------------------------------------------------
// ar_texture_vibration_synth_tb
// Self-checking bench for the autoregressive texture vibration synthesizer.
// A short table of directed transactions covers reset state, field extremes,
// every mode, the exact-limit and clamp cases and oversized tap counts. Random
// phases follow, each setting tap count and gain, and mostly load a bank, set
// its noise scale and run a burst of samples while the other bank is
// refilled. Results are checked against the table or a bit-accurate software filter.
// ----------------------------------------------------------------------------
module ar_texture_vibration_synth_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TAPS = 32;
  localparam int N_ITEMS = 950;
  localparam int LAT_TAIL = MAX_TAPS + 16;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         mode;
    logic               bank;
    logic signed [15:0] noise;
    logic [4:0]         tap_index;
    logic signed [31:0] coef;
    logic [23:0]        scale;
  } synth_item_t;

  typedef struct {
    logic signed [24:0] drive;
    logic signed [31:0] raw;
    logic               clamped;
  } drive_result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_TAPS, ROW_GAIN} row_kind_e;

  typedef struct {
    row_kind_e     kind;
    synth_item_t   it;
    logic [23:0]   data;
    bit            typed;
    drive_result_t res;
  } plan_row_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [artvs_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [artvs_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic [1:0]                       mode_i;
  logic                             bank_i;
  logic signed [15:0]               noise_sample_i;
  logic [4:0]                       tap_index_i;
  logic signed [31:0]               coefficient_i;
  logic [23:0]                      noise_scale_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic signed [24:0]               drive_value_o;
  logic signed [31:0]               raw_sample_o;
  logic                             clamped_o;

  // mirror of the block state
  logic [5:0]         taps_mirror;
  logic [23:0]        gain_mirror;
  logic signed [31:0] hist_mirror [MAX_TAPS];
  logic signed [31:0] coef_mirror [2][MAX_TAPS];
  logic [23:0]        scale_mirror [2];

  drive_result_t sample_due_q[$];
  plan_row_t     plan_q[$];
  int            mismatch_cnt = 0;
  int            item_cnt = 0;
  int unsigned   cycle_cnt = 0;
  bit            steady = 1'b0;

  ar_texture_vibration_synth #(.MAX_TAPS(MAX_TAPS)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .bank_i         (bank_i),
    .noise_sample_i (noise_sample_i),
    .tap_index_i    (tap_index_i),
    .coefficient_i  (coefficient_i),
    .noise_scale_i  (noise_scale_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_value_o  (drive_value_o),
    .raw_sample_o   (raw_sample_o),
    .clamped_o      (clamped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // one filter step: excitation minus feedback, round, saturate, shift history, gain, clamp
  function automatic drive_result_t synth_sample(logic bank, logic signed [15:0] noise);
    drive_result_t r;
    longint acc, h, c, raw, gained, n, s, g;
    int taps, i;
    taps = (taps_mirror > MAX_TAPS) ? MAX_TAPS : int'(taps_mirror);
    n = noise;
    s = scale_mirror[bank];
    acc = n * s;
    for (i = 0; i < taps; i++) begin
      h = hist_mirror[i];
      c = coef_mirror[bank][i];
      acc -= (h * c) >>> 16;
    end
    raw = (acc + 128) >>> 8;
    if (raw > 64'sd2147483647) raw = 64'sd2147483647;
    if (raw < -64'sd2147483648) raw = -64'sd2147483648;
    for (i = MAX_TAPS - 1; i >= 1; i--)
      hist_mirror[i] = (i - 1 < taps) ? hist_mirror[i-1] : '0;
    hist_mirror[0] = raw[31:0];
    g = gain_mirror;
    gained = (raw * g + 32768) >>> 16;
    r.clamped = 1'b0;
    if (gained > longint'(artvs_pkg::DRIVE_LIMIT)) begin
      gained = artvs_pkg::DRIVE_LIMIT;
      r.clamped = 1'b1;
    end
    if (gained < -longint'(artvs_pkg::DRIVE_LIMIT)) begin
      gained = -longint'(artvs_pkg::DRIVE_LIMIT);
      r.clamped = 1'b1;
    end
    r.drive = gained[24:0];
    r.raw = raw[31:0];
    return r;
  endfunction

  function automatic synth_item_t rand_item();
    synth_item_t it;
    it.mode = 2'($urandom_range(3));
    it.bank = 1'($urandom_range(1));
    it.noise = 16'($urandom);
    it.tap_index = 5'($urandom);
    it.coef = 32'($urandom);
    it.scale = 24'($urandom);
    return it;
  endfunction

  function automatic void row(row_kind_e kind, logic [1:0] mode, logic bank,
                             logic signed [15:0] noise, logic [4:0] idx,
                             logic signed [31:0] coef, logic [23:0] data, bit typed,
                             logic signed [24:0] drv, logic signed [31:0] raw, logic clp);
    plan_row_t p;
    p.kind = kind;
    p.it.mode = mode;
    p.it.bank = bank;
    p.it.noise = noise;
    p.it.tap_index = idx;
    p.it.coef = coef;
    p.it.scale = data;
    p.data = data;
    p.typed = typed;
    p.res.drive = drv;
    p.res.raw = raw;
    p.res.clamped = clp;
    plan_q.insert(plan_q.size(), p);
  endfunction

  task automatic write_reg(logic [artvs_pkg::CFG_IDX_W-1:0] idx,
                           logic [artvs_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == artvs_pkg::CFG_TAP_COUNT) taps_mirror = data[5:0];
    else gain_mirror = data;
    @(posedge clk_i);
  endtask

  // hold off until every sample has come back and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sample_due_q.size() != 0) @(posedge clk_i);
    repeat (LAT_TAIL) @(posedge clk_i);
  endtask

  task automatic send_item(synth_item_t it, bit typed, drive_result_t typed_res);
    drive_result_t r;
    if (!steady && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= it.mode;
    bank_i <= it.bank;
    noise_sample_i <= it.noise;
    tap_index_i <= it.tap_index;
    coefficient_i <= it.coef;
    noise_scale_i <= it.scale;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    item_cnt++;
    case (it.mode)
      artvs_pkg::MODE_SAMPLE: begin
        r = synth_sample(it.bank, it.noise);
        if (typed) sample_due_q.insert(sample_due_q.size(), typed_res);
        else sample_due_q.insert(sample_due_q.size(), r);
      end
      artvs_pkg::MODE_COEF: begin
        if (it.tap_index < MAX_TAPS) coef_mirror[it.bank][it.tap_index] = it.coef;
      end
      artvs_pkg::MODE_SCALE: scale_mirror[it.bank] = it.scale;
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 37);
  end

  always @(posedge clk_i) begin
    drive_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sample_due_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 200)
          $display("%0t: unexpected result drive %0d raw %0d clamped %0b",
                   $time, drive_value_o, raw_sample_o, clamped_o);
      end else begin
        e = sample_due_q.pop_front();
        if (drive_value_o !== e.drive || raw_sample_o !== e.raw ||
            clamped_o !== e.clamped) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 200)
            $display("%0t: expected drive %0d raw %0d clamped %0b, got %0d %0d %0b",
                     $time, e.drive, e.raw, e.clamped,
                     drive_value_o, raw_sample_o, clamped_o);
        end
      end
    end
  end

  initial begin
    synth_item_t   it;
    drive_result_t no_res;
    logic [5:0]    taps_val;
    logic [17:0]   junk;
    int            nt, m, k;
    bit            b;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    mode_i = artvs_pkg::MODE_SAMPLE;
    bank_i = 1'b0;
    noise_sample_i = '0;
    tap_index_i = '0;
    coefficient_i = '0;
    noise_scale_i = '0;
    no_res = '{default: '0};
    taps_mirror = '0;
    gain_mirror = artvs_pkg::GAIN_RESET;
    foreach (hist_mirror[i]) hist_mirror[i] = '0;
    foreach (coef_mirror[i, j]) coef_mirror[i][j] = '0;
    foreach (scale_mirror[i]) scale_mirror[i] = '0;

    //  kind      mode                    bk  noise   idx coef          data   chk drive  raw  clp
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 0, 16'h7FFF, 0, 0,            0,        1, 0,         0,        0);
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 1, -32768,   0, 0,            0,        1, 0,         0,        0);
    row(ROW_ITEM, artvs_pkg::MODE_SCALE,  0, 0,        0, 0,            24'h010000, 0, 0,       0,        0);
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 0, 4096,     0, 0,            0,        1, 1677728,   1048576,  0);
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 0, -32768,   0, 0,            0,        1, -10485760, -8388608, 1);
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 0, 32767,    0, 0,            0,        1, 10485760,  8388352,  1);
    // unused mode carries live-looking fields and must change nothing
    row(ROW_ITEM, MODE_UNUSED,            1, 4096,    31, -1,           24'hFFFFFF, 0, 0,       0,        0);
    row(ROW_ITEM, artvs_pkg::MODE_COEF,   1, 0,       31, 32'h80000000, 0,        0, 0,         0,        0);
    row(ROW_ITEM, artvs_pkg::MODE_COEF,   0, 0,        0, 32'h7FFFFFFF, 0,        0, 0,         0,        0);
    row(ROW_ITEM, artvs_pkg::MODE_SCALE,  1, 0,        0, 0,            24'hFFFFFF, 0, 0,       0,        0);
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 1, 0,        0, 0,            0,        1, 0,         0,        0);
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 1, 1,        0, 0,            0,        1, 104858,    65536,    0);
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 1, -1,       0, 0,            0,        1, -104858,   -65536,   0);
    // gain of exactly ten: the limit itself passes unclamped
    row(ROW_GAIN, artvs_pkg::MODE_SAMPLE, 0, 0,        0, 0,            24'd655360, 0, 0,       0,        0);
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 0, 4096,     0, 0,            0,        1, 10485760,  1048576,  0);
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 0, -4096,    0, 0,            0,        1, -10485760, -1048576, 0);
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 0, 4097,     0, 0,            0,        1, 10485760,  1048832,  1);
    row(ROW_GAIN, artvs_pkg::MODE_SAMPLE, 0, 0,        0, 0,            0,        0, 0,         0,        0);
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 1, 32767,    0, 0,            0,        0, 0,         0,        0);
    row(ROW_GAIN, artvs_pkg::MODE_SAMPLE, 0, 0,        0, 0,            24'hFFFFFF, 0, 0,       0,        0);
    // tap count past the history depth behaves as full depth
    row(ROW_TAPS, artvs_pkg::MODE_SAMPLE, 0, 0,        0, 0,            24'd63,   0, 0,         0,        0);
    row(ROW_ITEM, artvs_pkg::MODE_COEF,   0, 0,        1, 32'hFF800000, 0,        0, 0,         0,        0);
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 0, 32767,    0, 0,            0,        0, 0,         0,        0);
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 0, -32768,   0, 0,            0,        0, 0,         0,        0);
    row(ROW_ITEM, artvs_pkg::MODE_SAMPLE, 1, 12345,    0, 0,            0,        0, 0,         0,        0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      case (plan_q[i].kind)
        ROW_TAPS: begin
          settle();
          write_reg(artvs_pkg::CFG_TAP_COUNT, plan_q[i].data);
        end
        ROW_GAIN: begin
          settle();
          write_reg(artvs_pkg::CFG_OUTPUT_GAIN, plan_q[i].data);
        end
        default: send_item(plan_q[i].it, plan_q[i].typed, plan_q[i].res);
      endcase
    end

    while (item_cnt < N_ITEMS) begin
      settle();
      steady <= (item_cnt >= 400 && item_cnt < 560);
      case ($urandom_range(5))
        0: taps_val = 6'd0;
        1: taps_val = 6'd1;
        2: taps_val = 6'd32;
        3: taps_val = 6'($urandom_range(33, 63));
        default: taps_val = 6'($urandom_range(2, 12));
      endcase
      junk = 18'($urandom);
      write_reg(artvs_pkg::CFG_TAP_COUNT, {junk, taps_val});
      case ($urandom_range(7))
        0: write_reg(artvs_pkg::CFG_OUTPUT_GAIN, 24'd0);
        1: write_reg(artvs_pkg::CFG_OUTPUT_GAIN, 24'hFFFFFF);
        2: write_reg(artvs_pkg::CFG_OUTPUT_GAIN, artvs_pkg::GAIN_RESET);
        default: write_reg(artvs_pkg::CFG_OUTPUT_GAIN, 24'($urandom_range(24'h3FFFF)));
      endcase

      if ($urandom_range(99) < 80) begin
        // load a filter, usually stable, into one bank, then run samples mostly from it
        b = 1'($urandom_range(1));
        nt = (taps_val > MAX_TAPS) ? MAX_TAPS : int'(taps_val);
        m = 16777216 / (nt + 1);
        if ($urandom_range(9) == 0) m = m * 4;
        for (k = 0; k < nt; k++) begin
          it = rand_item();
          it.mode = artvs_pkg::MODE_COEF;
          it.bank = b;
          it.tap_index = 5'(k);
          it.coef = int'($urandom_range(2 * m)) - m;
          send_item(it, 1'b0, no_res);
        end
        it = rand_item();
        it.mode = artvs_pkg::MODE_SCALE;
        it.bank = b;
        it.scale = 24'($urandom_range(24'h3FFFF));
        send_item(it, 1'b0, no_res);
        repeat ($urandom_range(8, 40)) begin
          it = rand_item();
          case ($urandom_range(19))
            0: begin
              it.mode = artvs_pkg::MODE_COEF;
              it.bank = !b;
            end
            1: begin
              it.mode = artvs_pkg::MODE_SCALE;
              it.bank = !b;
            end
            2: it.mode = MODE_UNUSED;
            3: begin
              it.mode = artvs_pkg::MODE_SAMPLE;
              it.bank = !b;
            end
            default: begin
              it.mode = artvs_pkg::MODE_SAMPLE;
              it.bank = b;
            end
          endcase
          send_item(it, 1'b0, no_res);
        end
      end else begin
        repeat ($urandom_range(15, 35)) send_item(rand_item(), 1'b0, no_res);
      end
    end

    steady <= 1'b0;
    settle();
    if (mismatch_cnt == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
